// ===== rtl/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, register codes and types of the 3D automaton step engine.
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 4096;

    // Clamped size widths (1..MAX) and coordinate widths (0..MAX-1)
    localparam int SX_W = $clog2(MAX_X + 1);
    localparam int SY_W = $clog2(MAX_Y + 1);
    localparam int SZ_W = $clog2(MAX_Z + 1);
    localparam int X_W  = $clog2(MAX_X);
    localparam int Y_W  = $clog2(MAX_Y);
    localparam int Z_W  = $clog2(MAX_Z);

    localparam int PL_W  = SX_W + SY_W;
    localparam int TOT_W = PL_W + SZ_W;

    // Ring of recent cells, addressed by stream position modulo its length
    localparam int LAG_MAX  = MAX_X * MAX_Y + MAX_X + 1;
    localparam int RING_LEN = 2 * LAG_MAX + 2;
    localparam int RA_W     = $clog2(RING_LEN);

    // Configuration port
    localparam int LIM_W  = 5;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] REG_DEATH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_BIRTH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SIZE_X = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SIZE_Y = 3'd3;
    localparam logic [CIDX_W-1:0] REG_SIZE_Z = 3'd4;

    localparam logic [LIM_W-1:0] DEATH_RST  = 5'd15;
    localparam logic [LIM_W-1:0] BIRTH_RST  = 5'd17;
    localparam logic [8:0]       SIZE_X_RST = 9'd256;
    localparam logic [8:0]       SIZE_Y_RST = 9'd256;
    localparam logic [12:0]      SIZE_Z_RST = 13'd256;

    // Neighborhood: row index = (dz+1)*3 + (dy+1), bit = row*3 + (dx+1)
    localparam int NROW   = 9;
    localparam int NB_W   = 27;
    localparam int CENTER = 13;

    // Queue between front and back; depth is a power of two
    localparam int QD   = 4;
    localparam int QA_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    // Output data layout
    localparam int OD_W      = 32;
    localparam int OD_X_LO   = 1;
    localparam int OD_Y_LO   = OD_X_LO + X_W;
    localparam int OD_Z_LO   = OD_Y_LO + Y_W;
    localparam int OD_USED   = OD_Z_LO + Z_W;

    typedef struct packed {
        logic              we;
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic [NB_W-1:0] nb;
        logic [X_W-1:0]  x;
        logic [Y_W-1:0]  y;
        logic [Z_W-1:0]  z;
        logic            last;
    } t_cell;

    typedef struct packed {
        logic  valid;
        t_cell entry;
    } t_push;

endpackage

// ===== rtl/cas_ram.sv =====
// ----------------------------------------------------------------------------
// cas_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/cas_front.sv =====
// ----------------------------------------------------------------------------
// cas_front
// Accepts items, tracks stream positions, stores cells in the ring and
// gathers the 27-cell neighborhood of every cell that becomes ready.
// ----------------------------------------------------------------------------
module cas_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cas_pkg::t_cfg_wr          i_cfg,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_req_type,
    input  logic                      i_cell_alive,
    input  logic [cas_pkg::QC_W-1:0]  i_q_count,
    output cas_pkg::t_push            o_push
);

    localparam int RW = cas_pkg::RA_W + 1;

    logic [8:0]  r_size_x;
    logic [8:0]  r_size_y;
    logic [12:0] r_size_z;
    logic [1:0]  r_settle;

    logic [cas_pkg::SX_W-1:0] sx;
    logic [cas_pkg::SY_W-1:0] sy;
    logic [cas_pkg::SZ_W-1:0] sz;

    logic [cas_pkg::PL_W-1:0]  r_sxsy;
    logic [cas_pkg::TOT_W-1:0] r_total;
    logic [cas_pkg::TOT_W-1:0] r_lag;
    logic [cas_pkg::RA_W-1:0]  r_off0 [cas_pkg::NROW];
    logic [cas_pkg::RA_W-1:0]  r_off1 [cas_pkg::NROW];
    logic [cas_pkg::RA_W-1:0]  n_off0 [cas_pkg::NROW];
    logic [cas_pkg::RA_W-1:0]  n_off1 [cas_pkg::NROW];

    logic [cas_pkg::TOT_W-1:0] r_in;
    logic [cas_pkg::TOT_W-1:0] r_out;
    logic [cas_pkg::RA_W-1:0]  r_in_a;
    logic [cas_pkg::RA_W-1:0]  r_out_a;
    logic [cas_pkg::X_W-1:0]   r_ox;
    logic [cas_pkg::Y_W-1:0]   r_oy;
    logic [cas_pkg::Z_W-1:0]   r_oz;

    logic                      acc;
    logic                      wr;
    logic                      emit;
    logic                      size_wr;
    logic [cas_pkg::TOT_W-1:0] in_nx;
    logic [cas_pkg::TOT_W-1:0] gap;
    logic                      x0, xm, y0, ym, z0, zm;
    logic [cas_pkg::RA_W-1:0]  in_a_nx;
    logic [cas_pkg::RA_W-1:0]  out_a_nx;
    logic [cas_pkg::RA_W-1:0]  ra0 [cas_pkg::NROW];
    logic [cas_pkg::RA_W-1:0]  ra1 [cas_pkg::NROW];
    logic [cas_pkg::NROW-1:0]  rd0;
    logic [cas_pkg::NROW-1:0]  rd1;

    // Gather stage
    logic                      r_g_valid;
    logic [cas_pkg::X_W-1:0]   r_gx;
    logic [cas_pkg::Y_W-1:0]   r_gy;
    logic [cas_pkg::Z_W-1:0]   r_gz;
    logic                      r_glast;
    logic [5:0]                r_gedge;
    logic [cas_pkg::NROW-1:0]  r_byp0;
    logic [cas_pkg::NROW-1:0]  r_byp1;
    logic                      r_wd;
    logic [cas_pkg::NROW-1:0]  r_prev;
    logic [cas_pkg::NROW-1:0]  dx0;
    logic [cas_pkg::NROW-1:0]  dx1;
    logic [cas_pkg::NB_W-1:0]  nb;

    // Clamp sizes to 1..MAX
    always_comb begin
        if (r_size_x == '0) begin
            sx = cas_pkg::SX_W'(1);
        end else if (int'(r_size_x) > cas_pkg::MAX_X) begin
            sx = cas_pkg::SX_W'(cas_pkg::MAX_X);
        end else begin
            sx = cas_pkg::SX_W'(r_size_x);
        end
        if (r_size_y == '0) begin
            sy = cas_pkg::SY_W'(1);
        end else if (int'(r_size_y) > cas_pkg::MAX_Y) begin
            sy = cas_pkg::SY_W'(cas_pkg::MAX_Y);
        end else begin
            sy = cas_pkg::SY_W'(r_size_y);
        end
        if (r_size_z == '0) begin
            sz = cas_pkg::SZ_W'(1);
        end else if (int'(r_size_z) > cas_pkg::MAX_Z) begin
            sz = cas_pkg::SZ_W'(cas_pkg::MAX_Z);
        end else begin
            sz = cas_pkg::SZ_W'(r_size_z);
        end
    end

    // Ring offsets of each neighborhood row relative to the center cell
    always_comb begin
        logic [RW-1:0] pos;
        logic [RW-1:0] neg;
        logic [RW-1:0] off;
        for (int r = 0; r < cas_pkg::NROW; r++) begin
            pos = '0;
            neg = '0;
            if (r / 3 == 2) pos = pos + RW'(r_sxsy);
            if (r / 3 == 0) neg = neg + RW'(r_sxsy);
            if (r % 3 == 2) pos = pos + RW'(sx);
            if (r % 3 == 0) neg = neg + RW'(sx);
            if (pos >= neg) begin
                off = pos - neg;
            end else begin
                off = pos + RW'(cas_pkg::RING_LEN) - neg;
            end
            n_off0[r] = cas_pkg::RA_W'(off);
            off = off + RW'(1);
            if (off == RW'(cas_pkg::RING_LEN)) off = '0;
            n_off1[r] = cas_pkg::RA_W'(off);
        end
    end

    assign size_wr = i_cfg.we && (i_cfg.idx == cas_pkg::REG_SIZE_X ||
                                  i_cfg.idx == cas_pkg::REG_SIZE_Y ||
                                  i_cfg.idx == cas_pkg::REG_SIZE_Z);

    assign o_in_ready = (((cas_pkg::QC_W + 1)'(i_q_count) + (cas_pkg::QC_W + 1)'(r_g_valid))
                         < (cas_pkg::QC_W + 1)'(cas_pkg::QD)) && (r_settle == '0);

    always_comb begin
        logic [RW-1:0] s;
        acc   = i_in_valid && o_in_ready;
        wr    = acc && !i_req_type && (r_in < r_total);
        in_nx = r_in + cas_pkg::TOT_W'(wr);
        gap   = in_nx - r_out;
        emit  = acc && ((in_nx == r_total) || (gap >= r_lag));

        x0 = (r_ox == '0);
        y0 = (r_oy == '0);
        z0 = (r_oz == '0);
        xm = (cas_pkg::SX_W'(r_ox) == sx - cas_pkg::SX_W'(1));
        ym = (cas_pkg::SY_W'(r_oy) == sy - cas_pkg::SY_W'(1));
        zm = (cas_pkg::SZ_W'(r_oz) == sz - cas_pkg::SZ_W'(1));

        s = RW'(r_in_a) + RW'(1);
        if (s == RW'(cas_pkg::RING_LEN)) s = '0;
        in_a_nx = cas_pkg::RA_W'(s);
        s = RW'(r_out_a) + RW'(1);
        if (s == RW'(cas_pkg::RING_LEN)) s = '0;
        out_a_nx = cas_pkg::RA_W'(s);

        for (int r = 0; r < cas_pkg::NROW; r++) begin
            s = RW'(r_out_a) + RW'(r_off0[r]);
            if (s >= RW'(cas_pkg::RING_LEN)) s = s - RW'(cas_pkg::RING_LEN);
            ra0[r] = cas_pkg::RA_W'(s);
            s = RW'(r_out_a) + RW'(r_off1[r]);
            if (s >= RW'(cas_pkg::RING_LEN)) s = s - RW'(cas_pkg::RING_LEN);
            ra1[r] = cas_pkg::RA_W'(s);
        end
    end

    for (genvar r = 0; r < cas_pkg::NROW; r++) begin : g_row
        cas_ram #(
            .WIDTH (1),
            .DEPTH (cas_pkg::RING_LEN)
        ) u_ring (
            .i_clk     (i_clk),
            .i_we      (wr),
            .i_waddr   (r_in_a),
            .i_wdata   (i_cell_alive),
            .i_raddr_a (ra0[r]),
            .i_raddr_b (ra1[r]),
            .o_rdata_a (rd0[r]),
            .o_rdata_b (rd1[r])
        );
    end

    // Hold off input after a size write while derived sizes settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else if (size_wr) begin
            r_settle <= 2'd2;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // Configuration, derived sizes and stream positions
    always_ff @(posedge i_clk) begin
        r_sxsy  <= cas_pkg::PL_W'(sx) * cas_pkg::PL_W'(sy);
        r_total <= cas_pkg::TOT_W'(r_sxsy) * cas_pkg::TOT_W'(sz);
        r_lag   <= cas_pkg::TOT_W'(r_sxsy) + cas_pkg::TOT_W'(sx) + cas_pkg::TOT_W'(1);
        r_off0  <= n_off0;
        r_off1  <= n_off1;
        if (!i_rst_n) begin
            r_size_x <= cas_pkg::SIZE_X_RST;
            r_size_y <= cas_pkg::SIZE_Y_RST;
            r_size_z <= cas_pkg::SIZE_Z_RST;
            r_in     <= '0;
            r_out    <= '0;
            r_in_a   <= '0;
            r_out_a  <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_oz     <= '0;
        end else if (size_wr) begin
            case (i_cfg.idx)
                cas_pkg::REG_SIZE_X: r_size_x <= i_cfg.data[8:0];
                cas_pkg::REG_SIZE_Y: r_size_y <= i_cfg.data[8:0];
                cas_pkg::REG_SIZE_Z: r_size_z <= i_cfg.data[12:0];
                default: ;
            endcase
            // Abandon the current generation
            r_in    <= '0;
            r_out   <= '0;
            r_in_a  <= '0;
            r_out_a <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
        end else if (emit && xm && ym && zm) begin
            r_in    <= '0;
            r_out   <= '0;
            r_in_a  <= '0;
            r_out_a <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
        end else begin
            if (wr) begin
                r_in   <= in_nx;
                r_in_a <= in_a_nx;
            end
            if (emit) begin
                r_out   <= r_out + cas_pkg::TOT_W'(1);
                r_out_a <= out_a_nx;
                if (xm) begin
                    r_ox <= '0;
                    if (ym) begin
                        r_oy <= '0;
                        r_oz <= r_oz + cas_pkg::Z_W'(1);
                    end else begin
                        r_oy <= r_oy + cas_pkg::Y_W'(1);
                    end
                end else begin
                    r_ox <= r_ox + cas_pkg::X_W'(1);
                end
            end
        end
    end

    // Gather stage: capture position, edges and same-cycle write bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= emit;
        end
        r_gx    <= r_ox;
        r_gy    <= r_oy;
        r_gz    <= r_oz;
        r_glast <= xm && ym && zm;
        r_gedge <= {zm, z0, ym, y0, xm, x0};
        r_wd    <= i_cell_alive;
        for (int r = 0; r < cas_pkg::NROW; r++) begin
            r_byp0[r] <= wr && (ra0[r] == r_in_a);
            r_byp1[r] <= wr && (ra1[r] == r_in_a);
        end
        // Center column of this cell is the left column of the next one
        if (r_g_valid) begin
            r_prev <= dx0;
        end
    end

    always_comb begin
        logic row_out;
        for (int r = 0; r < cas_pkg::NROW; r++) begin
            dx0[r] = r_byp0[r] ? r_wd : rd0[r];
            dx1[r] = r_byp1[r] ? r_wd : rd1[r];
            row_out = (r / 3 == 0 && r_gedge[4]) || (r / 3 == 2 && r_gedge[5]) ||
                      (r % 3 == 0 && r_gedge[2]) || (r % 3 == 2 && r_gedge[3]);
            // Cells outside the volume count as alive
            nb[r * 3]     = row_out || r_gedge[0] || r_prev[r];
            nb[r * 3 + 1] = row_out || dx0[r];
            nb[r * 3 + 2] = row_out || r_gedge[1] || dx1[r];
        end
        o_push.valid      = r_g_valid;
        o_push.entry.nb   = nb;
        o_push.entry.x    = r_gx;
        o_push.entry.y    = r_gy;
        o_push.entry.z    = r_gz;
        o_push.entry.last = r_glast;
    end

endmodule

// ===== rtl/cas_queue.sv =====
// ----------------------------------------------------------------------------
// cas_queue
// Short queue of gathered cells between the front and the back.
// ----------------------------------------------------------------------------
module cas_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cas_pkg::t_push           i_push,
    input  logic                     i_pop,
    output cas_pkg::t_cell           o_head,
    output logic [cas_pkg::QC_W-1:0] o_count
);

    cas_pkg::t_cell           r_mem [cas_pkg::QD];
    logic [cas_pkg::QA_W-1:0] r_wp;
    logic [cas_pkg::QA_W-1:0] r_rp;
    logic [cas_pkg::QC_W-1:0] r_cnt;
    logic                     pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.entry;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            // Front only pushes when a slot is free
            if (i_push.valid) r_wp <= r_wp + cas_pkg::QA_W'(1);
            if (pop) r_rp <= r_rp + cas_pkg::QA_W'(1);
            r_cnt <= r_cnt + cas_pkg::QC_W'(i_push.valid) - cas_pkg::QC_W'(pop);
        end
    end

endmodule

// ===== rtl/cas_back.sv =====
// ----------------------------------------------------------------------------
// cas_back
// Counts live neighbors, applies the survival and birth rule and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module cas_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cas_pkg::t_cfg_wr          i_cfg,
    input  cas_pkg::t_cell            i_head,
    input  logic [cas_pkg::QC_W-1:0]  i_q_count,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cas_pkg::OD_W-1:0]  o_data,
    output logic                      o_last
);

    localparam logic [cas_pkg::NB_W-1:0] NB_MASK = ~(cas_pkg::NB_W'(1) << cas_pkg::CENTER);

    logic [cas_pkg::LIM_W-1:0] r_death;
    logic [cas_pkg::LIM_W-1:0] r_birth;
    logic [4:0]                cnt;
    logic                      alive;
    logic                      next;

    assign o_pop = (i_q_count != '0) && (!o_valid || i_ready);

    always_comb begin
        cnt   = 5'($countones(i_head.nb & NB_MASK));
        alive = i_head.nb[cas_pkg::CENTER];
        next  = alive ? (cnt >= r_death) : (cnt > r_birth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_death <= cas_pkg::DEATH_RST;
            r_birth <= cas_pkg::BIRTH_RST;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg.we && i_cfg.idx == cas_pkg::REG_DEATH) begin
                r_death <= i_cfg.data[cas_pkg::LIM_W-1:0];
            end
            if (i_cfg.we && i_cfg.idx == cas_pkg::REG_BIRTH) begin
                r_birth <= i_cfg.data[cas_pkg::LIM_W-1:0];
            end
            if (o_pop) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
        // Load on pop, hold otherwise
        if (o_pop) begin
            o_data <= {(cas_pkg::OD_W - cas_pkg::OD_USED)'(0),
                       i_head.z, i_head.y, i_head.x, next};
            o_last <= i_head.last;
        end
    end

endmodule

// ===== rtl/cellular_automaton_3d_step.sv =====
// ----------------------------------------------------------------------------
// cellular_automaton_3d_step
// One generation step of a 3D binary automaton over a streamed cell volume.
// ----------------------------------------------------------------------------
// Cells arrive in raster order (x fastest, then y, then z) and the block
// takes one item per clock, flush or cell, except while input is held off
// by a full queue or a size register write. The result of cell p leaves
// once cell p + size_x*size_y + size_x + 1 has arrived or the volume is
// complete, so results lag the input by that many cell items; flush items
// drain the tail, one result each. Between the item that releases a result
// and its presentation lie the ring read and gather at the accepting edge,
// the queue write, and the output register, loaded through the count and
// rule once the output is free. The stream is kept in nine copies of a
// 131588 by 1 ring memory, one per neighborhood row, each with one write and
// two read ports; its contents are undefined after reset and need no
// clearing pass. After a size register write the input is held off while
// derived sizes settle. Reset is synchronous and active low.
module cellular_automaton_3d_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] cell_alive
    input  logic                      s_axis_tuser,   // [0] req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [cas_pkg::OD_W-1:0]  m_axis_tdata,   // [0] new_alive, [8:1] pos_x,
                                                      // [16:9] pos_y, [28:17] pos_z
    output logic                      m_axis_tlast,   // last_cell
    input  logic                      i_cfg_we,
    input  logic [cas_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [cas_pkg::CFG_W-1:0] i_cfg_data
);

    cas_pkg::t_cfg_wr           cfg;
    cas_pkg::t_push             push;
    cas_pkg::t_cell             head;
    logic [cas_pkg::QC_W-1:0]   q_count;
    logic                       pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    cas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_cell_alive (s_axis_tdata[0]),
        .i_q_count    (q_count),
        .o_push       (push)
    );

    cas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    cas_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_head    (head),
        .i_q_count (q_count),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

// ===== rtl/cas_checker.sv =====
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks of the step engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module cas_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [cas_pkg::OD_W-1:0]   m_axis_tdata,
    input logic                       m_axis_tlast,
    input logic                       i_cfg_we,
    input logic [cas_pkg::CIDX_W-1:0] i_cfg_idx
);

    logic r_seen;
    logic r_first;

    // Track whether the next result must be the origin of a generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            if (s_axis_tvalid && s_axis_tready) r_seen <= 1'b1;
            if (i_cfg_we && (i_cfg_idx == cas_pkg::REG_SIZE_X ||
                             i_cfg_idx == cas_pkg::REG_SIZE_Y ||
                             i_cfg_idx == cas_pkg::REG_SIZE_Z)) begin
                r_first <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_first <= m_axis_tlast;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_seen)
        else $error("result without any accepted item");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_first |->
            m_axis_tdata[cas_pkg::OD_USED-1:cas_pkg::OD_X_LO] == '0)
        else $error("generation does not start at the origin");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[cas_pkg::OD_W-1:cas_pkg::OD_USED] == '0)
        else $error("padding bits set in result");

endmodule

bind cellular_automaton_3d_step cas_checker u_cas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx)
);

// ===== tb/cellular_automaton_3d_step_test.sv =====
// ----------------------------------------------------------------------------
// cellular_automaton_3d_step_test
// Streams small cell volumes through the 3D automaton step engine, predicts
// each next-generation cell with a behavioral window count, and checks every
// result item field by field under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cellular_automaton_3d_step_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE = 12;
    localparam logic [cas_pkg::CIDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic flush;
        logic alive;
    } t_req;

    typedef struct packed {
        logic                     alive;
        logic [cas_pkg::X_W-1:0]  x;
        logic [cas_pkg::Y_W-1:0]  y;
        logic [cas_pkg::Z_W-1:0]  z;
        logic                     last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;    // [0] cell_alive
    logic s_axis_tuser = 1'b0;        // [0] req_type
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [cas_pkg::OD_W-1:0] m_axis_tdata;   // [0] new_alive, [8:1] x, [16:9] y, [28:17] z
    logic m_axis_tlast;
    logic i_cfg_we = 1'b0;
    logic [cas_pkg::CIDX_W-1:0] i_cfg_idx = '0;
    logic [cas_pkg::CFG_W-1:0] i_cfg_data = '0;

    cellular_automaton_3d_step DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    int unsigned death_lim, birth_lim, sx, sy, sz;
    int unsigned in_pos, out_pos;
    bit          ring_bits [cas_pkg::RING_LEN];

    t_req pending_items[$];
    t_res expected_cells[$];
    int   fail_count = 0;
    bit   calm = 1'b0;
    longint cycles = 0;
    logic in_fire = 1'b0;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned alive_neighbors(int unsigned p);
        int unsigned x, y, z, cnt;
        int nx, ny, nz;
        x = p % sx;
        y = (p / sx) % sy;
        z = p / (sx * sy);
        cnt = 0;
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx == 0 && dy == 0 && dz == 0) continue;
                    nx = int'(x) + dx;
                    ny = int'(y) + dy;
                    nz = int'(z) + dz;
                    if (nx < 0 || ny < 0 || nz < 0 || nx >= int'(sx) || ny >= int'(sy)
                        || nz >= int'(sz))
                        cnt++;
                    else
                        cnt += ring_bits[((nz * sy + ny) * sx + nx) % cas_pkg::RING_LEN];
                end
        return cnt;
    endfunction

    // advance the predictor by one accepted item
    task automatic predict_step(t_req r);
        int unsigned total, need, cnt;
        t_res res;
        total = sx * sy * sz;
        if (!r.flush && in_pos < total) begin
            ring_bits[in_pos % cas_pkg::RING_LEN] = r.alive;
            in_pos++;
        end
        if (out_pos >= total) return;
        need = out_pos + sx * sy + sx + 1;
        if (need > total) need = total;
        if (in_pos < need) return;
        cnt = alive_neighbors(out_pos);
        res.alive = ring_bits[out_pos % cas_pkg::RING_LEN] ? (cnt >= death_lim)
                                                             : (cnt > birth_lim);
        res.x = cas_pkg::X_W'(out_pos % sx);
        res.y = cas_pkg::Y_W'((out_pos / sx) % sy);
        res.z = cas_pkg::Z_W'(out_pos / (sx * sy));
        res.last = (out_pos + 1 == total);
        expected_cells.push_back(res);
        out_pos++;
        if (out_pos >= total) begin
            out_pos = 0;
            in_pos = 0;
        end
    endtask

    task automatic write_reg(logic [cas_pkg::CIDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= cas_pkg::CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cas_pkg::REG_DEATH: death_lim = val & 5'h1F;
            cas_pkg::REG_BIRTH: birth_lim = val & 5'h1F;
            cas_pkg::REG_SIZE_X: begin
                sx = clamp_size(val & 9'h1FF, cas_pkg::MAX_X);
                in_pos = 0;
                out_pos = 0;
            end
            cas_pkg::REG_SIZE_Y: begin
                sy = clamp_size(val & 9'h1FF, cas_pkg::MAX_Y);
                in_pos = 0;
                out_pos = 0;
            end
            cas_pkg::REG_SIZE_Z: begin
                sz = clamp_size(val & 13'h1FFF, cas_pkg::MAX_Z);
                in_pos = 0;
                out_pos = 0;
            end
            default: ;
        endcase
        repeat (4) @(negedge i_clk);
    endtask

    // wait for the stimulus queue to empty and all results to drain
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
               && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // one full generation with content of the given live density, plus flushes
    task automatic push_volume(int density);
        int unsigned total, lag;
        t_req r;
        total = sx * sy * sz;
        lag = sx * sy + sx + 1;
        if (lag > total) lag = total;
        for (int unsigned i = 0; i < total; i++) begin
            r.flush = ($urandom_range(0, 19) == 0);
            r.alive = ($urandom_range(0, 99) < density);
            pending_items.push_back(r);
            if (r.flush) i--;
        end
        for (int unsigned i = 0; i < lag + 1; i++) begin
            r.flush = 1'b1;
            r.alive = $urandom_range(0, 1);
            pending_items.push_back(r);
        end
    endtask

    // input accept as seen at the rising edge
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    // driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_fire) begin
                // hold
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_items[0].flush;
                s_axis_tdata <= {7'd0, pending_items[0].alive};
                void'(pending_items.pop_front());
                if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 9);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink ready
    int snk_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 9);
        end
    end

    // monitor: predict on accept, check on result
    always @(posedge i_clk) begin
        t_res exp_r;
        t_req r;
        cycles <= cycles + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            r.flush = s_axis_tuser;
            r.alive = s_axis_tdata[0];
            predict_step(r);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells.size() == 0) begin
                $error("unexpected result item: tdata=%h", m_axis_tdata);
                fail_count++;
            end else begin
                exp_r = expected_cells.pop_front();
                if (m_axis_tdata[0] !== exp_r.alive) begin
                    $error("new_alive: expected %0d, actual %0d", exp_r.alive, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[cas_pkg::OD_Y_LO-1:cas_pkg::OD_X_LO] !== exp_r.x) begin
                    $error("pos_x: expected %0d, actual %0d", exp_r.x,
                           m_axis_tdata[cas_pkg::OD_Y_LO-1:cas_pkg::OD_X_LO]);
                    fail_count++;
                end
                if (m_axis_tdata[cas_pkg::OD_Z_LO-1:cas_pkg::OD_Y_LO] !== exp_r.y) begin
                    $error("pos_y: expected %0d, actual %0d", exp_r.y,
                           m_axis_tdata[cas_pkg::OD_Z_LO-1:cas_pkg::OD_Y_LO]);
                    fail_count++;
                end
                if (m_axis_tdata[cas_pkg::OD_USED-1:cas_pkg::OD_Z_LO] !== exp_r.z) begin
                    $error("pos_z: expected %0d, actual %0d", exp_r.z,
                           m_axis_tdata[cas_pkg::OD_USED-1:cas_pkg::OD_Z_LO]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_r.last) begin
                    $error("last_cell: expected %0d, actual %0d", exp_r.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int sent;
        death_lim = cas_pkg::DEATH_RST;
        birth_lim = cas_pkg::BIRTH_RST;
        sx = cas_pkg::SIZE_X_RST;
        sy = cas_pkg::SIZE_Y_RST;
        sz = cas_pkg::SIZE_Z_RST;
        in_pos = 0;
        out_pos = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiny volumes, clamping, limit extremes
        write_reg(cas_pkg::REG_SIZE_X, 0);
        write_reg(cas_pkg::REG_SIZE_Y, 300);
        write_reg(cas_pkg::REG_SIZE_Y, 1);
        write_reg(cas_pkg::REG_SIZE_Z, 0);
        write_reg(cas_pkg::REG_DEATH, 0);
        write_reg(cas_pkg::REG_BIRTH, 0);
        pending_items.push_back('{1'b1, 1'b0});   // flush with nothing ready
        pending_items.push_back('{1'b0, 1'b1});
        pending_items.push_back('{1'b0, 1'b0});
        pending_items.push_back('{1'b1, 1'b1});
        drain();
        write_reg(cas_pkg::REG_DEATH, 31);
        write_reg(cas_pkg::REG_BIRTH, 31);
        write_reg(REG_NONE, 5);                     // unknown index, ignored
        write_reg(cas_pkg::REG_SIZE_X, 3);
        write_reg(cas_pkg::REG_SIZE_Z, 2);
        for (int i = 0; i < 6; i++) pending_items.push_back('{1'b0, i[0]});
        // extra cells after the whole volume arrived, then drain
        for (int i = 0; i < 3; i++) pending_items.push_back('{1'b0, 1'b1});
        for (int i = 0; i < 6; i++) pending_items.push_back('{1'b1, 1'b0});
        drain();

        // widest x in one row; also fills the low ring entries for later volumes
        write_reg(cas_pkg::REG_DEATH, 15);
        write_reg(cas_pkg::REG_BIRTH, 17);
        write_reg(cas_pkg::REG_SIZE_X, 256);
        write_reg(cas_pkg::REG_SIZE_Y, 1);
        write_reg(cas_pkg::REG_SIZE_Z, 1);
        push_volume(50);
        drain();

        // random volumes
        sent = 0;
        while (sent < 350) begin
            write_reg(cas_pkg::REG_DEATH, $urandom_range(0, 27));
            write_reg(cas_pkg::REG_BIRTH, $urandom_range(0, 27));
            write_reg(cas_pkg::REG_SIZE_X, $urandom_range(1, 6));
            write_reg(cas_pkg::REG_SIZE_Y, $urandom_range(1, 5));
            write_reg(cas_pkg::REG_SIZE_Z, $urandom_range(1, 5));
            if (sent > 250) calm = 1'b1;
            push_volume($urandom_range(0, 100));
            sent += pending_items.size();
            drain();
        end

        // clamped depth: first planes of an oversized column
        calm = 1'b1;
        write_reg(cas_pkg::REG_SIZE_X, 1);
        write_reg(cas_pkg::REG_SIZE_Y, 1);
        write_reg(cas_pkg::REG_SIZE_Z, 5000);
        for (int i = 0; i < 40; i++) pending_items.push_back('{1'b0, i[1]});
        drain();

        if (fail_count == 0 && expected_cells.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
